// File: rtl/core/trsc_pkg.sv
// ----------------------------------------------------------------------------
// trsc_pkg
// Shared types, codes and helpers for the three-rotor substitution cipher.
// ----------------------------------------------------------------------------
package trsc_pkg;

    localparam int ROTOR_LENGTH = 26;
    localparam int ROTOR_IDX_W  = $clog2(ROTOR_LENGTH);
    localparam int ROTOR_SUM_W  = ROTOR_IDX_W + 1;

    localparam logic [ROTOR_SUM_W-1:0] ROT_ONE = ROTOR_SUM_W'(ROTOR_LENGTH);
    localparam logic [ROTOR_SUM_W-1:0] ROT_TWO = ROTOR_SUM_W'(2 * ROTOR_LENGTH);
    localparam logic [ROTOR_IDX_W-1:0] ROT_LAST = ROTOR_IDX_W'(ROTOR_LENGTH - 1);

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] ALPHA_COUNT  = 8'(ROTOR_LENGTH);

    // item kind, carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    typedef enum logic [1:0] {
        SEL_FIRST  = 2'd0,
        SEL_SECOND = 2'd1,
        SEL_THIRD  = 2'd2,
        SEL_NONE   = 2'd3
    } rotor_sel_t;

    typedef struct packed {
        logic                   en;
        rotor_sel_t             sel;
        logic [ROTOR_IDX_W-1:0] idx;
        logic [ROTOR_IDX_W-1:0] val;
    } rotor_wr_t;

    typedef struct packed {
        logic [ROTOR_IDX_W-1:0] p1;
        logic [ROTOR_IDX_W-1:0] p2;
        logic [ROTOR_IDX_W-1:0] p3;
    } rotor_pos_t;

    // reduce a value below three rotor lengths into one rotor length
    function automatic logic [ROTOR_IDX_W-1:0] wrap_index(input logic [ROTOR_SUM_W-1:0] v);
        logic [ROTOR_SUM_W-1:0] r;
        if (v >= ROT_TWO) begin
            r = v - ROT_TWO;
        end else if (v >= ROT_ONE) begin
            r = v - ROT_ONE;
        end else begin
            r = v;
        end
        return r[ROTOR_IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/trsc_rotor_bank.sv
// ----------------------------------------------------------------------------
// trsc_rotor_bank
// Holds the three rotor tables and maps a letter index through the stack.
// ----------------------------------------------------------------------------
module trsc_rotor_bank (
    input  logic                           aclk,
    input  trsc_pkg::rotor_wr_t            wr,
    input  trsc_pkg::rotor_pos_t           pos,
    input  logic [trsc_pkg::ROTOR_IDX_W-1:0] letter_idx,
    output logic [trsc_pkg::ROTOR_IDX_W-1:0] code
);
    import trsc_pkg::*;

    logic [ROTOR_IDX_W-1:0] r1_reg [ROTOR_LENGTH];
    logic [ROTOR_IDX_W-1:0] r2_reg [ROTOR_LENGTH];
    logic [ROTOR_IDX_W-1:0] r3_reg [ROTOR_LENGTH];

    logic [ROTOR_IDX_W-1:0] a1, a2, a3;
    logic [ROTOR_IDX_W-1:0] v1, v2, v3;

    // out-of-range index or select writes nothing; no reset on table contents
    always_ff @(posedge aclk) begin
        if (wr.en && (wr.idx <= ROT_LAST)) begin
            unique case (wr.sel)
                SEL_FIRST:  r1_reg[wr.idx] <= wr.val;
                SEL_SECOND: r2_reg[wr.idx] <= wr.val;
                SEL_THIRD:  r3_reg[wr.idx] <= wr.val;
                default: ;
            endcase
        end
    end

    always_comb begin
        a1   = wrap_index({1'b0, letter_idx} + {1'b0, pos.p1});
        v1   = r1_reg[a1];
        a2   = wrap_index({1'b0, v1} + {1'b0, pos.p2});
        v2   = r2_reg[a2];
        a3   = wrap_index({1'b0, v2} + {1'b0, pos.p3});
        v3   = r3_reg[a3];
        code = wrap_index({1'b0, v3});
    end

endmodule

// File: rtl/core/three_rotor_substitution_cipher_unit.sv
// ----------------------------------------------------------------------------
// three_rotor_substitution_cipher_unit
// A text word accepted on s_ goes to the input register, then to the result
// register that drives m_. Throughput: one word per cycle while m_ is not
// stalled; the input register feeds the rotor lookup chain and the result
// register in the same cycle. Load words give no result. Reset clears the
// positions and both valid flags; rotor tables hold old contents until written.
// ----------------------------------------------------------------------------
module three_rotor_substitution_cipher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rotor_select[1:0], entry_index[6:2],
                                   // entry_value[11:7], text_byte[19:12], zero
    input  logic        s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // out_byte[7:0]
);
    import trsc_pkg::*;

    logic                   in_valid_reg;
    logic                   in_cmd_reg;
    rotor_sel_t             in_sel_reg;
    logic [ROTOR_IDX_W-1:0] in_idx_reg;
    logic [ROTOR_IDX_W-1:0] in_val_reg;
    logic [7:0]             in_byte_reg;

    logic                   m_valid_reg;
    logic [7:0]             m_data_reg;

    rotor_pos_t             pos_reg, pos_next;

    logic                   out_free, fire, is_load, is_text;
    logic                   is_upper, is_lower, is_letter;
    logic [7:0]             base, offs, result;
    logic [ROTOR_IDX_W-1:0] code;
    rotor_wr_t              wr;

    assign is_load  = (in_cmd_reg == CMD_LOAD);
    assign is_text  = (in_cmd_reg == CMD_TEXT);
    assign out_free = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && (is_load || out_free);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign is_upper  = (in_byte_reg >= CHAR_UPPER_A) && (in_byte_reg < CHAR_UPPER_A + ALPHA_COUNT);
    assign is_lower  = (in_byte_reg >= CHAR_LOWER_A) && (in_byte_reg < CHAR_LOWER_A + ALPHA_COUNT);
    assign is_letter = is_upper || is_lower;
    assign base      = is_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    assign offs      = in_byte_reg - base;
    assign result    = is_letter ? (base + {{(8-ROTOR_IDX_W){1'b0}}, code}) : in_byte_reg;

    assign wr.en  = fire && is_load;
    assign wr.sel = in_sel_reg;
    assign wr.idx = in_idx_reg;
    assign wr.val = in_val_reg;

    trsc_rotor_bank u_bank (
        .aclk       (aclk),
        .wr         (wr),
        .pos        (pos_reg),
        .letter_idx (offs[ROTOR_IDX_W-1:0]),
        .code       (code)
    );

    // odometer stepping
    always_comb begin
        pos_next = pos_reg;
        if (fire && is_load) begin
            pos_next = '0;
        end else if (fire && is_text && is_letter) begin
            if (pos_reg.p1 == ROT_LAST) begin
                pos_next.p1 = '0;
                if (pos_reg.p2 == ROT_LAST) begin
                    pos_next.p2 = '0;
                    pos_next.p3 = (pos_reg.p3 == ROT_LAST) ? '0 : pos_reg.p3 + 1'b1;
                end else begin
                    pos_next.p2 = pos_reg.p2 + 1'b1;
                end
            end else begin
                pos_next.p1 = pos_reg.p1 + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pos_reg      <= '0;
        end else begin
            pos_reg <= pos_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire && is_text) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_sel_reg  <= rotor_sel_t'(s_tdata[1:0]);
            in_idx_reg  <= s_tdata[6:2];
            in_val_reg  <= s_tdata[11:7];
            in_byte_reg <= s_tdata[19:12];
        end
        if (fire && is_text) begin
            m_data_reg <= result;
        end
    end

endmodule

// File: rtl/core/trsc_checker.sv
// ----------------------------------------------------------------------------
// trsc_checker
// Port-level checks on the cipher unit: hold rules and word occupancy.
// ----------------------------------------------------------------------------
module trsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    import trsc_pkg::*;

    // text words taken but not yet delivered
    logic [1:0] pend_reg, pend_next;
    logic       text_in, word_out;

    assign text_in  = s_tvalid && s_tready && (s_tuser == CMD_TEXT);
    assign word_out = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (text_in && !word_out) begin
            pend_next = pend_reg + 2'd1;
        end else if (!text_in && word_out) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 2'd2)
        else $error("more text words in flight than registers");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result word with no text word pending");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> pend_reg == 2'd2)
        else $error("input stalled while a register is free");

endmodule

bind three_rotor_substitution_cipher_unit trsc_checker u_trsc_checker (.*);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the three-rotor substitution cipher. The rotor
// tables are filled with shuffled permutations first. A short table of
// directed words follows: byte extremes, letter edges, and loads that are
// ignored or out of range. Random traffic comes last: one long message that
// carries the second rotor through its wrap, then reload/message sequences
// mixed with noise. Every result word is checked against a local model of
// the tables and positions, or against a byte typed into the directed table.
// Both sides idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trsc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 1150;
    localparam int LONG_LETTERS = 700;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       cmd;
        rotor_sel_t sel;
        logic [4:0] idx;
        logic [4:0] val;
        logic [7:0] ch;
        bit         typed;
        logic [7:0] want;
    } stim_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [23:0] s_tdata = '0;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    // travels with the word on s_: an expectation typed into the directed table
    bit         typed_ok   = 1'b0;
    logic [7:0] typed_byte = '0;

    logic [4:0] rotor_map [3][ROTOR_LENGTH];
    int         rotor_pos [3] = '{0, 0, 0};
    logic [7:0] cipher_q [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int words_sent     = 0;
    int burst_left     = 0;
    bit sender_idles   = 1'b1;
    bit hold_req       = 1'b0;

    stim_row_t directed_rows [24] = '{
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h00, 1'b1, 8'h00},
        '{CMD_TEXT, SEL_NONE,   5'd31, 5'd31, 8'hFF, 1'b1, 8'hFF},
        '{CMD_TEXT, SEL_THIRD,  5'd25, 5'd25, 8'h40, 1'b1, 8'h40},  // '@'
        '{CMD_TEXT, SEL_SECOND, 5'd26, 5'd0,  8'h5B, 1'b1, 8'h5B},  // '['
        '{CMD_TEXT, SEL_FIRST,  5'd1,  5'd30, 8'h60, 1'b1, 8'h60},  // '`'
        '{CMD_TEXT, SEL_NONE,   5'd30, 5'd1,  8'h7B, 1'b1, 8'h7B},  // '{'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h80, 1'b1, 8'h80},
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h41, 1'b0, 8'h00},  // 'A'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h5A, 1'b0, 8'h00},  // 'Z'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h61, 1'b0, 8'h00},  // 'a'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h7A, 1'b0, 8'h00},  // 'z'
        // select three writes nothing; the load still clears the positions
        '{CMD_LOAD, SEL_NONE,   5'd5,  5'd7,  8'hAA, 1'b0, 8'h00},
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h4D, 1'b0, 8'h00},  // 'M'
        '{CMD_LOAD, SEL_FIRST,  5'd31, 5'd31, 8'h55, 1'b0, 8'h00},
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h71, 1'b0, 8'h00},  // 'q'
        // values past the table end are kept as given
        '{CMD_LOAD, SEL_THIRD,  5'd25, 5'd31, 8'h00, 1'b0, 8'h00},
        '{CMD_LOAD, SEL_SECOND, 5'd0,  5'd31, 8'hFF, 1'b0, 8'h00},
        '{CMD_LOAD, SEL_FIRST,  5'd0,  5'd25, 8'h00, 1'b0, 8'h00},
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h41, 1'b0, 8'h00},  // 'A'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h7A, 1'b0, 8'h00},  // 'z'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h30, 1'b1, 8'h30},  // '0'
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h5A, 1'b0, 8'h00},  // 'Z'
        '{CMD_LOAD, SEL_SECOND, 5'd26, 5'd0,  8'h00, 1'b0, 8'h00},
        '{CMD_TEXT, SEL_FIRST,  5'd0,  5'd0,  8'h42, 1'b0, 8'h00}   // 'B'
    };

    three_rotor_substitution_cipher_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // cipher state update for one accepted word; gives is set for text words
    function automatic void encipher_word(input logic cmd, input rotor_sel_t sel,
                                          input logic [4:0] idx, input logic [4:0] val,
                                          input logic [7:0] ch, output bit gives,
                                          output logic [7:0] res);
        int base;
        int a;
        int b;
        int c;
        gives = 1'b0;
        res   = '0;
        if (cmd == CMD_LOAD) begin
            if (sel != SEL_NONE && idx < ROTOR_LENGTH) begin
                rotor_map[int'(sel)][idx] = val;
            end
            rotor_pos = '{0, 0, 0};
            return;
        end
        gives = 1'b1;
        res   = ch;
        if (ch >= CHAR_UPPER_A && ch < CHAR_UPPER_A + ALPHA_COUNT) begin
            base = CHAR_UPPER_A;
        end else if (ch >= CHAR_LOWER_A && ch < CHAR_LOWER_A + ALPHA_COUNT) begin
            base = CHAR_LOWER_A;
        end else begin
            return;
        end
        a = rotor_map[0][(int'(ch) - base + rotor_pos[0]) % ROTOR_LENGTH];
        b = rotor_map[1][(a + rotor_pos[1]) % ROTOR_LENGTH];
        c = rotor_map[2][(b + rotor_pos[2]) % ROTOR_LENGTH];
        res = 8'(base + c % ROTOR_LENGTH);
        // odometer stepping
        rotor_pos[0] = (rotor_pos[0] + 1) % ROTOR_LENGTH;
        if (rotor_pos[0] == 0) begin
            rotor_pos[1] = (rotor_pos[1] + 1) % ROTOR_LENGTH;
            if (rotor_pos[1] == 0) begin
                rotor_pos[2] = (rotor_pos[2] + 1) % ROTOR_LENGTH;
            end
        end
    endfunction

    function automatic logic [7:0] rand_text(input int letter_pct);
        if ($urandom_range(99) < letter_pct) begin
            return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(25));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
        mismatch_count++;
    endtask

    // entered and left just after a falling edge
    task automatic send_word(input logic cmd, input rotor_sel_t sel, input logic [4:0] idx,
                             input logic [4:0] val, input logic [7:0] ch,
                             input bit typed = 1'b0, input logic [7:0] want = '0);
        if (sender_idles && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= cmd;
        s_tdata    <= {4'b0, ch, val, idx, sel};
        typed_ok   <= typed;
        typed_byte <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) burst_left--;
        words_sent++;
    endtask

    task automatic send_rand_load(input bit wild);
        rotor_sel_t sel;
        logic [4:0] idx;
        logic [4:0] val;
        sel = wild ? rotor_sel_t'($urandom_range(3)) : rotor_sel_t'($urandom_range(2));
        idx = wild ? 5'($urandom_range(31)) : 5'($urandom_range(ROTOR_LENGTH - 1));
        val = wild ? 5'($urandom_range(31)) : 5'($urandom_range(ROTOR_LENGTH - 1));
        send_word(CMD_LOAD, sel, idx, val, 8'($urandom_range(255)));
    endtask

    // full reload of all three tables with shuffled permutations
    task automatic load_rotor_set();
        int perm [ROTOR_LENGTH];
        int j;
        int t;
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < ROTOR_LENGTH; i++) perm[i] = i;
            for (int i = ROTOR_LENGTH - 1; i > 0; i--) begin
                j = $urandom_range(i);
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (int i = 0; i < ROTOR_LENGTH; i++) begin
                send_word(CMD_LOAD, rotor_sel_t'(r), 5'(i), 5'(perm[i]),
                          8'($urandom_range(255)));
            end
        end
    endtask

    // checks m_ words, then models the word taken on s_ at the same edge
    always @(posedge aclk) begin : scoreboard
        logic [7:0] want;
        bit         gives;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("word with none expected", m_tdata, 'x);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_tdata !== want) report_mismatch("out_byte", m_tdata, want);
                end
            end
            if (s_tvalid && s_tready) begin
                encipher_word(s_tuser, rotor_sel_t'(s_tdata[1:0]), s_tdata[6:2],
                              s_tdata[11:7], s_tdata[19:12], gives, want);
                if (gives) cipher_q.push_back(typed_ok ? typed_byte : want);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        int mode;
        int span;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            mode = $urandom_range(3);
            span = $urandom_range(10, 80);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(1));
                    2: m_tready <= (k % 4 == 0);
                    default: m_tready <= ($urandom_range(7) != 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int letters;
        int len;
        int pick;
        logic [7:0] ch;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load_rotor_set();
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].cmd, directed_rows[i].sel, directed_rows[i].idx,
                      directed_rows[i].val, directed_rows[i].ch, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // long message: the second rotor wraps and the third one steps;
        // the receiver stalls hard somewhere inside it
        load_rotor_set();
        hold_req = 1'b1;
        letters  = 0;
        while (letters < LONG_LETTERS) begin
            ch = rand_text(95);
            if ((ch >= CHAR_UPPER_A && ch < CHAR_UPPER_A + ALPHA_COUNT) ||
                (ch >= CHAR_LOWER_A && ch < CHAR_LOWER_A + ALPHA_COUNT)) begin
                letters++;
            end
            send_word(CMD_TEXT, rotor_sel_t'($urandom_range(3)), 5'($urandom_range(31)),
                      5'($urandom_range(31)), ch);
        end

        while (words_sent < ITEM_TARGET) begin
            sender_idles = ($urandom_range(3) != 0);
            pick = $urandom_range(99);
            if (pick < 4) begin
                load_rotor_set();
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) send_rand_load($urandom_range(9) == 0);
                len = $urandom_range(5, 60);
                repeat (len) begin
                    send_word(CMD_TEXT, rotor_sel_t'($urandom_range(3)),
                              5'($urandom_range(31)), 5'($urandom_range(31)), rand_text(85));
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(1)) begin
                        send_rand_load(1'b1);
                    end else begin
                        send_word(CMD_TEXT, rotor_sel_t'($urandom_range(3)),
                                  5'($urandom_range(31)), 5'($urandom_range(31)),
                                  8'($urandom_range(255)));
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        while (cipher_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/trsc_pkg.sv
rtl/core/trsc_rotor_bank.sv
rtl/core/three_rotor_substitution_cipher_unit.sv
rtl/core/trsc_checker.sv
bench/tb_top.sv
